@@ hw/rtl/qlu_pkg.sv @@
`default_nettype none

package qlu_pkg;

  localparam int VAL_W  = 32;
  localparam int RATE_W = 17;
  localparam int ACT_W  = 5;
  localparam int NST_W  = 12;
  localparam int CFG_AW = 2;

  localparam logic [RATE_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [RATE_W-1:0] LEARN_RATE_RST = 17'd32768;
  localparam logic [RATE_W-1:0] DISCOUNT_RST   = 17'd58982;
  localparam logic [VAL_W-1:0]  GOAL_RST       = 32'd327680;

  // register indexes of the configuration port
  localparam logic [CFG_AW-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_DISCOUNT   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_GOAL       = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_SCAN,
    ST_OLDRD,
    ST_MUL1,
    ST_TGT,
    ST_MUL2,
    ST_WRITE
  } qlu_state_t;

  // rates above one are used as one
  function automatic logic [RATE_W-1:0] rate_clamp(input logic [RATE_W-1:0] r);
    rate_clamp = (r > ONE_Q16) ? ONE_Q16 : r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/q_learning_table_update.sv @@
// an accepted item passes address, row scan through the single read port of the
//   value memory, old-value read, two passes of the shared multiplier, write-back;
//   then out_valid is registered; one item at a time, in_stall is low only in idle
// reset: synchronous active-low; a clearing pass zeroes all NUM_STATES*NUM_ACTIONS
//   table entries, in_stall stays high meanwhile, config writes accepted
`default_nettype none

module q_learning_table_update #(
  parameter int NUM_STATES  = 4096,
  parameter int NUM_ACTIONS = 27
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [qlu_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [qlu_pkg::VAL_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [qlu_pkg::ACT_W-1:0]   in_action,
  input  wire logic [qlu_pkg::NST_W-1:0]   in_next_state,
  input  wire logic signed [qlu_pkg::VAL_W-1:0] in_reward,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [qlu_pkg::VAL_W-1:0] out_new_value,
  output logic signed [qlu_pkg::VAL_W-1:0] out_next_max,
  output logic                             out_episode_done
);
  import qlu_pkg::*;

  localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SW     = $clog2(NUM_STATES);
  localparam int AW     = $clog2(NUM_ACTIONS);

  qlu_state_t state_r, state_nxt;

  logic [RATE_W-1:0] learn_rate_r, discount_r;
  logic signed [VAL_W-1:0] goal_r;

  logic [SW-1:0] cur_r, nxt_r;
  logic [AW-1:0] act_r, rd_idx_r;
  logic signed [VAL_W-1:0] reward_r, best_r, old_r;
  logic [ADDR_W-1:0] base_r, old_addr_r, clr_addr_r;
  logic scan_vld_r, scan_first_r;

  logic signed [52:0] mul_r;
  logic signed [34:0] diff_r;

  logic out_vld_r, done_r;
  logic signed [VAL_W-1:0] nv_r, max_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;
  logic              mul_alpha;

  logic in_acc, out_free, wr_go, clr_last, scan_last;
  logic [SW-1:0] nxt_in_c;
  logic [AW-1:0] act_in_c;

  logic signed [17:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [52:0] mul_rnd, acc, acc_rnd;
  logic signed [VAL_W-1:0] nv;
  logic done_c;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_vld_r || !out_stall;
  assign wr_go     = (state_r == ST_WRITE) && out_free;
  assign clr_last  = clr_addr_r == ADDR_W'(DEPTH - 1);
  assign scan_last = rd_idx_r == AW'(NUM_ACTIONS - 1);

  // out-of-range indexes are used as the last one
  assign nxt_in_c = (32'(in_next_state) >= 32'(NUM_STATES)) ? SW'(NUM_STATES - 1)
                                                             : SW'(in_next_state);
  assign act_in_c = (32'(in_action) >= 32'(NUM_ACTIONS)) ? AW'(NUM_ACTIONS - 1)
                                                          : AW'(in_action);

  qlu_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_last) state_nxt = ST_OLDRD;
      ST_OLDRD: state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_TGT;
      ST_TGT:   state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_addr  = old_addr_r;
    ram_wdata = nv;
    mul_alpha = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = '0;
      end
      ST_IDLE:  in_stall = 1'b0;
      ST_SCAN:  ram_addr = base_r + ADDR_W'(rd_idx_r);
      ST_MUL2:  mul_alpha = 1'b1;
      ST_WRITE: ram_we = out_free;
      default:  ;
    endcase
  end

  // shared multiplier: discount*max, then alpha*(target-old)
  assign mul_a = mul_alpha ? $signed({1'b0, rate_clamp(learn_rate_r)})
                           : $signed({1'b0, rate_clamp(discount_r)});
  assign mul_b = mul_alpha ? diff_r : $signed({{3{best_r[VAL_W-1]}}, best_r});

  assign mul_rnd = (mul_r + 53'sd32768) >>> 16;
  // (1-a)*old + a*t == old*65536 + a*(t-old)
  assign acc     = $signed({{5{old_r[VAL_W-1]}}, old_r, 16'b0}) + mul_r;
  assign acc_rnd = (acc + 53'sd32768) >>> 16;

  always_comb begin
    if (acc_rnd > 53'sd2147483647) begin
      nv = 32'sh7fffffff;
    end else if (acc_rnd < -53'sd2147483648) begin
      nv = 32'sh80000000;
    end else begin
      nv = $signed(acc_rnd[VAL_W-1:0]);
    end
  end

  assign done_c = reward_r >= goal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      learn_rate_r <= LEARN_RATE_RST;
      discount_r   <= DISCOUNT_RST;
      goal_r       <= GOAL_RST;
      cur_r        <= '0;
      rd_idx_r     <= '0;
      scan_vld_r   <= 1'b0;
      scan_first_r <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_vld_r   <= state_r == ST_SCAN;
      scan_first_r <= (state_r == ST_SCAN) && (rd_idx_r == '0);
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_LEARN_RATE: learn_rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_DISCOUNT:   discount_r   <= cfg_wdata[RATE_W-1:0];
          CFG_GOAL:       goal_r       <= $signed(cfg_wdata);
          default:        ;
        endcase
      end
      if (state_r == ST_SCAN) begin
        rd_idx_r <= scan_last ? '0 : rd_idx_r + 1'b1;
      end
      if (wr_go) begin
        cur_r     <= done_c ? '0 : nxt_r;
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= act_in_c;
      nxt_r    <= nxt_in_c;
      reward_r <= in_reward;
    end
    if (state_r == ST_ADDR) begin
      base_r     <= ADDR_W'(nxt_r * NUM_ACTIONS);
      old_addr_r <= ADDR_W'(cur_r * NUM_ACTIONS) + ADDR_W'(act_r);
    end
    // row data comes from the registered memory read, in the cycle after its address
    if (scan_vld_r && (scan_first_r || $signed(ram_rdata) > best_r)) begin
      best_r <= $signed(ram_rdata);
    end
    if (state_r == ST_MUL1) begin
      old_r <= $signed(ram_rdata);
    end
    if (state_r == ST_MUL1 || state_r == ST_MUL2) begin
      mul_r <= mul_a * mul_b;
    end
    if (state_r == ST_TGT) begin
      diff_r <= $signed({{3{reward_r[VAL_W-1]}}, reward_r}) + $signed(mul_rnd[34:0])
                - $signed({{3{old_r[VAL_W-1]}}, old_r});
    end
    if (wr_go) begin
      nv_r   <= nv;
      max_r  <= best_r;
      done_r <= done_c;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_new_value    = nv_r;
  assign out_next_max     = max_r;
  assign out_episode_done = done_r;

  a_acc_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_ADDR)
    else $error("accepted item did not start the sequencer");

  a_we_only: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_WRITE))
    else $error("table written outside clear or write-back");

  a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == ST_WRITE)
    else $error("result appeared without a write-back");

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_r) < 32'(NUM_STATES))
    else $error("current state out of range");

  a_no_cfg_stall_leak: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && !out_free) |=> state_r == ST_WRITE && $stable(cur_r))
    else $error("write-back left while result register busy");

endmodule

`default_nettype wire

@@ hw/rtl/qlu_ram.sv @@
`default_nettype none

module qlu_ram #(
  parameter int DEPTH  = 110592,
  parameter int ADDR_W = 17
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        addr,
  input  wire logic [qlu_pkg::VAL_W-1:0] wdata,
  output logic      [qlu_pkg::VAL_W-1:0] rdata
);
  import qlu_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ verif/q_update_checker.sv @@
module q_update_checker #(
  parameter int NUM_STATES  = 4096,
  parameter int NUM_ACTIONS = 27
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [qlu_pkg::CFG_AW-1:0]        cfg_addr,
  input  wire logic [qlu_pkg::VAL_W-1:0]         cfg_wdata,
  input  wire logic                              in_valid,
  input  wire logic                              in_stall,
  input  wire logic [qlu_pkg::ACT_W-1:0]         in_action,
  input  wire logic [qlu_pkg::NST_W-1:0]         in_next_state,
  input  wire logic signed [qlu_pkg::VAL_W-1:0]  in_reward,
  input  wire logic                              out_valid,
  input  wire logic                              out_stall,
  input  wire logic signed [qlu_pkg::VAL_W-1:0]  out_new_value,
  input  wire logic signed [qlu_pkg::VAL_W-1:0]  out_next_max,
  input  wire logic                              out_episode_done,
  output int                                     mismatches,
  output int                                     outstanding
);
  import qlu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VAL_HI = 64'sd2147483647;
  localparam longint VAL_LO = -64'sd2147483648;

  typedef struct {
    logic signed [VAL_W-1:0] new_value;
    logic signed [VAL_W-1:0] next_max;
    logic                    episode_done;
  } q_update_t;

  // sparse copy of the value table, missing entries read as zero
  logic signed [VAL_W-1:0] q_vals [int unsigned];
  int unsigned             cur_state;
  logic [RATE_W-1:0]       alpha_reg;
  logic [RATE_W-1:0]       gamma_reg;
  logic signed [VAL_W-1:0] goal_reg;
  q_update_t               pending_updates [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic signed [VAL_W-1:0] stored(input int unsigned idx);
    return q_vals.exists(idx) ? q_vals[idx] : '0;
  endfunction

  // round half up then drop the 16 fraction bits
  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic q_update_t update_q(input logic [ACT_W-1:0] act_in,
                                         input logic [NST_W-1:0] nxt_in,
                                         input logic signed [VAL_W-1:0] rew);
    int unsigned             act;
    int unsigned             nxt;
    int unsigned             slot;
    logic signed [VAL_W-1:0] best;
    logic signed [VAL_W-1:0] entry;
    longint                  alpha;
    longint                  gamma;
    longint                  tgt;
    longint                  acc;
    q_update_t               res;
    act = (act_in >= NUM_ACTIONS) ? NUM_ACTIONS - 1 : act_in;
    nxt = (nxt_in >= NUM_STATES) ? NUM_STATES - 1 : nxt_in;
    best = stored(nxt * NUM_ACTIONS);
    for (int i = 1; i < NUM_ACTIONS; i++) begin
      entry = stored(nxt * NUM_ACTIONS + i);
      if (entry > best) best = entry;
    end
    alpha = (alpha_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(alpha_reg);
    gamma = (gamma_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(gamma_reg);
    tgt = longint'(rew) + round_q16(gamma * longint'(best));
    slot = cur_state * NUM_ACTIONS + act;
    acc = (longint'(ONE_Q16) - alpha) * longint'(stored(slot)) + alpha * tgt;
    acc = round_q16(acc);
    if (acc > VAL_HI) res.new_value = VAL_HI[VAL_W-1:0];
    else if (acc < VAL_LO) res.new_value = VAL_LO[VAL_W-1:0];
    else res.new_value = acc[VAL_W-1:0];
    q_vals[slot] = res.new_value;
    res.next_max = best;
    res.episode_done = (rew >= goal_reg);
    cur_state = res.episode_done ? 0 : nxt;
    return res;
  endfunction

  always @(posedge clk) begin
    q_update_t want;
    if (!rst_n) begin
      q_vals.delete();
      pending_updates.delete();
      cur_state = 0;
      alpha_reg = LEARN_RATE_RST;
      gamma_reg = DISCOUNT_RST;
      goal_reg  = GOAL_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LEARN_RATE: alpha_reg = cfg_wdata[RATE_W-1:0];
          CFG_DISCOUNT:   gamma_reg = cfg_wdata[RATE_W-1:0];
          CFG_GOAL:       goal_reg  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_updates.push_back(update_q(in_action, in_next_state, in_reward));
      if (out_valid && !out_stall) begin
        if (pending_updates.size() == 0) begin
          mismatches++;
          $display("%0t unexpected item: new_value %0d next_max %0d episode_done %0b",
                   $time, out_new_value, out_next_max, out_episode_done);
        end else begin
          want = pending_updates.pop_front();
          if (out_new_value !== want.new_value) begin
            mismatches++;
            $display("%0t new_value: expected %0d, got %0d",
                     $time, want.new_value, out_new_value);
          end
          if (out_next_max !== want.next_max) begin
            mismatches++;
            $display("%0t next_max: expected %0d, got %0d",
                     $time, want.next_max, out_next_max);
          end
          if (out_episode_done !== want.episode_done) begin
            mismatches++;
            $display("%0t episode_done: expected %0b, got %0b",
                     $time, want.episode_done, out_episode_done);
          end
        end
      end
    end
    outstanding <= pending_updates.size();
  end

endmodule

@@ verif/q_learning_table_update_tb.sv @@
module q_learning_table_update_tb;
  import qlu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_STATES  = 4096;
  localparam int NUM_ACTIONS = 27;
  localparam int ITEMS_PER_PHASE = 255;
  localparam int NUM_PHASES = 6;

  // index with no register behind it
  localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_AW-1:0]        cfg_addr = '0;
  logic [VAL_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [ACT_W-1:0]         in_action = '0;
  logic [NST_W-1:0]         in_next_state = '0;
  logic signed [VAL_W-1:0]  in_reward = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [VAL_W-1:0]  out_new_value;
  logic signed [VAL_W-1:0]  out_next_max;
  logic                     out_episode_done;

  int                       mismatches;
  int                       outstanding;
  logic                     quiet = 1'b0;
  logic                     calm = 1'b0;
  int                       stall_left = 0;
  logic signed [VAL_W-1:0]  goal_now = GOAL_RST;
  logic [NST_W-1:0]         last_next = '0;

  q_learning_table_update #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_next_state    (in_next_state),
    .in_reward        (in_reward),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_value    (out_new_value),
    .out_next_max     (out_next_max),
    .out_episode_done (out_episode_done)
  );

  q_update_checker #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_next_state    (in_next_state),
    .in_reward        (in_reward),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_value    (out_new_value),
    .out_next_max     (out_next_max),
    .out_episode_done (out_episode_done),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stretches with no idling on either side
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= !calm;
  end

  always @(posedge clk) begin
    if (quiet || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 13);
      out_stall <= 1'b1;
    end
  end

  // returns on the edge that accepts the item, or after the gap that follows it
  task automatic send_update(input logic [ACT_W-1:0] act, input logic [NST_W-1:0] nxt,
                             input logic signed [VAL_W-1:0] rew);
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_next_state <= nxt;
    in_reward <= rew;
    last_next = nxt;
    do @(posedge clk); while (in_stall);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int                      pick;
    logic [ACT_W-1:0]        act;
    logic [NST_W-1:0]        nxt;
    logic signed [VAL_W-1:0] rew;
    pick = $urandom_range(0, 99);
    if (pick < 85) act = ACT_W'($urandom_range(0, NUM_ACTIONS - 1));
    else act = ACT_W'($urandom);
    // a small pool of states so rows fill up and get revisited
    pick = $urandom_range(0, 99);
    if (pick < 65) nxt = NST_W'($urandom_range(0, 7));
    else if (pick < 75) nxt = last_next;
    else nxt = NST_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) rew = int'($urandom_range(0, 786432)) - 393216;
    else if (pick < 60) rew = goal_now + int'($urandom_range(0, 2)) - 1;
    else if (pick < 80) rew = $urandom;
    else if (pick < 90) rew = VAL_MAX;
    else rew = VAL_MIN;
    send_update(act, nxt, rew);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [VAL_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes, out of range actions, same row, goal edge
    send_update(0, 0, 0);
    send_update(26, 4095, 32'sd65536);
    send_update(27, 1, VAL_MAX);
    send_update(31, 4095, VAL_MIN);
    send_update(5, 4095, GOAL_RST);
    send_update(5, 0, GOAL_RST - 1);
    repeat (5) send_update(3, 0, VAL_MAX);
    repeat (4) send_update(4, 9, VAL_MIN);
    send_update(0, 12'haaa, 32'sh55555555);
    send_update(21, 12'h555, 32'shaaaaaaaa);
    send_update(26, 0, -1);
    send_update(10, 9, 1);

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      drain();
      case (ph)
        1: begin
          goal_now = VAL_MAX;
          write_reg(CFG_LEARN_RATE, 32'(ONE_Q16));
          write_reg(CFG_DISCOUNT, 32'(ONE_Q16));
          write_reg(CFG_GOAL, goal_now);
          write_reg(CFG_SPARE, $urandom);
        end
        2: begin
          goal_now = VAL_MIN;
          write_reg(CFG_LEARN_RATE, 0);
          write_reg(CFG_DISCOUNT, 0);
          write_reg(CFG_GOAL, goal_now);
        end
        3: begin
          // rates above one
          goal_now = 0;
          write_reg(CFG_LEARN_RATE, 32'h1ffff);
          write_reg(CFG_DISCOUNT, 32'h1ffff);
          write_reg(CFG_GOAL, goal_now);
        end
        4: begin
          goal_now = GOAL_RST;
          write_reg(CFG_LEARN_RATE, 1);
          write_reg(CFG_DISCOUNT, 65535);
          write_reg(CFG_GOAL, goal_now);
        end
        5: begin
          goal_now = int'($urandom_range(0, 1048576)) - 131072;
          write_reg(CFG_LEARN_RATE, $urandom_range(0, 65536));
          write_reg(CFG_DISCOUNT, $urandom_range(0, 65536));
          write_reg(CFG_GOAL, goal_now);
        end
        default: begin
          goal_now = GOAL_RST;
          write_reg(CFG_LEARN_RATE, 32'(LEARN_RATE_RST));
          write_reg(CFG_DISCOUNT, 32'(DISCOUNT_RST));
          write_reg(CFG_GOAL, goal_now);
          quiet <= 1'b1;
        end
      endcase
      cfg_we <= 1'b0;
      repeat (ITEMS_PER_PHASE) send_random();
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/qlu_pkg.sv
hw/rtl/qlu_ram.sv
hw/rtl/q_learning_table_update.sv
verif/q_update_checker.sv
verif/q_learning_table_update_tb.sv
